// ===== rtl/thadc_pkg.sv =====
// Shared constants and types for the thermistor ADC-to-temperature converter.
`timescale 1ns / 1ps

package thadc_pkg;

    // Field widths
    localparam int RES_W  = 32;   // resistance, unsigned Q16.16
    localparam int TEMP_W = 16;   // temperature, signed Q8.8
    localparam int ADC_W  = 10;   // raw converter reading
    localparam int IDX_W  = 6;    // load row index

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CNT_REG_W  = 7;
    localparam int PREC_W     = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_PREC  = 2'd1;
    localparam logic [CNT_REG_W-1:0] ENTRY_COUNT_RST = 7'd64;
    localparam logic [PREC_W-1:0]    MATCH_PREC_RST  = 16'd7;

    // Operation codes carried on the input tuser bit
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    // Table depth default
    localparam int DEF_TABLE_DEPTH = 64;

    // Resistance conversion: R = 3600*adc*2^16 / (33759 - 36*adc)
    localparam int ADC_GAIN  = 3600;
    localparam int DIV_BASE  = 33759;
    localparam int DIV_SLOPE = 36;
    localparam int ADC_LIMIT = 938;   // first sample with a divisor of zero or less
    localparam int FRAC_W    = 16;
    localparam int PRD_W     = 22;    // holds 3600 * 937
    localparam int DVD_W     = PRD_W + FRAC_W;
    localparam int DVS_W     = 16;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

endpackage

// ===== rtl/thermistor_adc_to_temperature.sv =====
// Top level: thermistor ADC sample to table-based temperature converter.
`timescale 1ns / 1ps

// Sequence: a load is written as it is accepted; a convert divides (prefetching the span
//   rows), searches, reads neighbors k-1, k+1, k, compares and loads the output; early hit,
//   span miss and no positive divisor skip ahead to the output load. Throughput: one convert
//   at a time, next word taken once its result is registered; a held output word stalls.
// Reset: synchronous, active low; clears sequencer, output valid and registers (entry_count
//   64, match_precision 7); table RAM keeps its contents and must be loaded before use.

module thermistor_adc_to_temperature #(
    parameter int TABLE_DEPTH = thadc_pkg::DEF_TABLE_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration write port
    input  logic                                 i_cfg_we,
    input  logic [thadc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [thadc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [5:0] entry_index, [37:6] entry_resistance, [53:38] entry_temperature,
    // [63:54] adc_sample
    input  logic [63:0]                          s_axis_tdata,
    // [0] operation
    input  logic [0:0]                           s_axis_tuser,
    // Output stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [15:0] temperature
    output logic [15:0]                          m_axis_tdata,
    // [0] out_of_range
    output logic [0:0]                           m_axis_tuser
);

    localparam int RW = thadc_pkg::RES_W;
    localparam int TW = thadc_pkg::TEMP_W;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = AW + 1;            // holds the effective entry count
    localparam int MW = RW + TW;           // RAM word: {temperature, resistance}

    // Input word field positions
    localparam int IDX_LO  = 0;
    localparam int RES_LO  = IDX_LO + thadc_pkg::IDX_W;
    localparam int TMP_LO  = RES_LO + RW;
    localparam int ADC_LO  = TMP_LO + TW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SRCH,
        S_FIN,
        S_PICK,
        S_EMIT
    } t_state;

    function automatic logic [RW-1:0] abs_gap(input logic [RW-1:0] a, input logic [RW-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // Configuration registers
    logic [thadc_pkg::CNT_REG_W-1:0] r_entry_count;
    logic [thadc_pkg::PREC_W-1:0]    r_match_prec;

    // Sequencer state and working registers
    t_state          r_state;
    logic [1:0]      r_step;
    logic [RW-1:0]   r_res;        // resistance of the sample
    logic [RW-1:0]   r_span_lo;    // resistance of the last row in use
    logic [RW-1:0]   r_span_hi;    // resistance of row 0
    logic [AW-1:0]   r_bot;
    logic [AW-1:0]   r_top;
    logic [AW-1:0]   r_mid;
    logic [RW-1:0]   r_g1, r_g2, r_g3;
    logic [TW-1:0]   r_t1, r_t2, r_t3;
    logic [TW-1:0]   r_res_temp;
    logic            r_res_oor;
    logic            r_m_valid;
    logic [TW-1:0]   r_m_temp;
    logic            r_m_oor;

    // Input word fields
    logic                        w_op;
    logic [thadc_pkg::IDX_W-1:0] w_idx;
    logic [RW-1:0]               w_wres;
    logic [TW-1:0]               w_wtemp;
    logic [thadc_pkg::ADC_W-1:0] w_adc;
    logic                        w_accept;

    assign w_op     = s_axis_tuser[0];
    assign w_idx    = s_axis_tdata[RES_LO-1:IDX_LO];
    assign w_wres   = s_axis_tdata[TMP_LO-1:RES_LO];
    assign w_wtemp  = s_axis_tdata[ADC_LO-1:TMP_LO];
    assign w_adc    = s_axis_tdata[ADC_LO+thadc_pkg::ADC_W-1:ADC_LO];
    assign w_accept = s_axis_tvalid && s_axis_tready;

    // Effective entry count: zero acts as one, clamp at the table depth
    logic [CW-1:0] w_cnt;
    logic [AW-1:0] w_last;
    logic [AW-1:0] w_mid0;

    always_comb begin
        priority if (r_entry_count == '0) begin
            w_cnt = CW'(1);
        end else if (32'(r_entry_count) > 32'(TABLE_DEPTH)) begin
            w_cnt = CW'(TABLE_DEPTH);
        end else begin
            w_cnt = CW'(r_entry_count);
        end
        w_last = AW'(w_cnt - 1'b1);
        w_mid0 = w_last >> 1;
    end

    // Table RAM
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_raddr;
    logic [MW-1:0] w_rdata;
    logic [RW-1:0] w_rd_res;
    logic [TW-1:0] w_rd_temp;

    assign w_we    = w_accept && (w_op == thadc_pkg::OP_LOAD)
                     && (32'(w_idx) < 32'(TABLE_DEPTH));
    assign w_waddr = AW'(w_idx);
    assign w_rd_res  = w_rdata[RW-1:0];
    assign w_rd_temp = w_rdata[MW-1:RW];

    thadc_ram #(
        .WIDTH (MW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata ({w_wtemp, w_wres}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Divider: start on an accepted convert with a positive divisor
    thadc_pkg::t_div_req w_div_req;
    logic                w_div_done;
    logic [RW-1:0]       w_quot;
    logic                w_adc_bad;

    assign w_adc_bad = (32'(w_adc) >= 32'(thadc_pkg::ADC_LIMIT));

    always_comb begin
        w_div_req.start    = w_accept && (w_op == thadc_pkg::OP_CONVERT) && !w_adc_bad;
        w_div_req.dividend = {thadc_pkg::PRD_W'(32'(w_adc) * 32'(thadc_pkg::ADC_GAIN)),
                              thadc_pkg::FRAC_W'(0)};
        w_div_req.divisor  = thadc_pkg::DVS_W'(32'(thadc_pkg::DIV_BASE)
                              - 32'(w_adc) * 32'(thadc_pkg::DIV_SLOPE));
    end

    thadc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // Span check on the fresh quotient
    logic w_span_out;
    assign w_span_out = (w_quot < r_span_lo) || (w_quot > r_span_hi);

    // One binary-search step against the row read last cycle
    logic [RW-1:0] n_gap;
    logic          n_hit;
    logic          n_lower;
    logic [AW-1:0] n_bot;
    logic [AW-1:0] n_top;
    logic [AW:0]   n_sum;
    logic [AW-1:0] n_mid;
    logic          n_more;

    always_comb begin
        n_gap   = abs_gap(r_res, w_rd_res);
        n_hit   = (n_gap < RW'(r_match_prec)) || (n_gap == '0);
        n_lower = (r_res < w_rd_res);
        n_bot   = n_lower ? r_mid : r_bot;
        n_top   = n_lower ? r_top : r_mid;
        n_sum   = (AW+1)'(n_bot) + (AW+1)'(n_top);
        n_mid   = n_sum[AW:1];
        n_more  = ((AW+1)'(n_bot) + 1'b1) < (AW+1)'(n_top);
    end

    // Final pick among k-1, k+1 and k; ties go to k-1, then k+1
    logic w_v1, w_v2, w_pick1, w_pick2;
    logic [TW-1:0] w_pick_temp;

    always_comb begin
        w_v1    = (r_mid != '0);
        w_v2    = (CW'(r_mid) + 1'b1) < w_cnt;
        w_pick1 = w_v1 && (!w_v2 || (r_g1 <= r_g2)) && (r_g1 <= r_g3);
        w_pick2 = w_v2 && (!w_v1 || (r_g2 <= r_g1)) && (r_g2 <= r_g3);
        priority if (w_pick1) begin
            w_pick_temp = r_t1;
        end else if (w_pick2) begin
            w_pick_temp = r_t2;
        end else begin
            w_pick_temp = r_t3;
        end
    end

    // Read address: prefetch span rows while dividing, then search, then neighbors
    always_comb begin
        unique case (r_state)
            S_DIV: begin
                priority if (w_div_done) begin
                    w_raddr = w_mid0;
                end else if (r_step == 2'd0) begin
                    w_raddr = w_last;
                end else begin
                    w_raddr = '0;
                end
            end
            S_SRCH:  w_raddr = n_mid;
            S_FIN: begin
                unique case (r_step)
                    2'd0:    w_raddr = r_mid - 1'b1;
                    2'd1:    w_raddr = r_mid + 1'b1;
                    default: w_raddr = r_mid;
                endcase
            end
            default: w_raddr = r_mid;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= thadc_pkg::ENTRY_COUNT_RST;
            r_match_prec  <= thadc_pkg::MATCH_PREC_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == thadc_pkg::CFG_ENTRY_COUNT) begin
                r_entry_count <= i_cfg_data[thadc_pkg::CNT_REG_W-1:0];
            end else if (i_cfg_index == thadc_pkg::CFG_MATCH_PREC) begin
                r_match_prec <= i_cfg_data[thadc_pkg::PREC_W-1:0];
            end
        end
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            // load a new output word in S_EMIT, otherwise drop the word once taken
            if (r_state == S_EMIT) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && (w_op == thadc_pkg::OP_CONVERT)) begin
                        r_step <= '0;
                        if (w_adc_bad) begin
                            // divisor zero or negative: out of range at once
                            r_res_temp <= '0;
                            r_res_oor  <= 1'b1;
                            r_state    <= S_EMIT;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end

                S_DIV: begin
                    // fetch the span rows while the quotient builds up
                    if (r_step == 2'd1) begin
                        r_span_lo <= w_rd_res;
                    end else if (r_step == 2'd2) begin
                        r_span_hi <= w_rd_res;
                    end
                    if (w_div_done) begin
                        r_res <= w_quot;
                        r_bot <= '0;
                        r_top <= w_last;
                        r_mid <= w_mid0;
                        r_step <= '0;
                        priority if (w_span_out) begin
                            r_res_temp <= '0;
                            r_res_oor  <= 1'b1;
                            r_state    <= S_EMIT;
                        end else if (32'(w_last) >= 32'd2) begin
                            r_state <= S_SRCH;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end else if (r_step != 2'd3) begin
                        r_step <= r_step + 1'b1;
                    end
                end

                S_SRCH: begin
                    priority if (n_hit) begin
                        r_res_temp <= w_rd_temp;
                        r_res_oor  <= 1'b0;
                        r_state    <= S_EMIT;
                    end else begin
                        // narrow the interval; the next row is already addressed
                        r_bot <= n_bot;
                        r_top <= n_top;
                        r_mid <= n_mid;
                        if (!n_more) begin
                            r_step  <= '0;
                            r_state <= S_FIN;
                        end
                    end
                end

                S_FIN: begin
                    // capture k-1, k+1, k in turn
                    unique case (r_step)
                        2'd1: begin
                            r_g1 <= n_gap;
                            r_t1 <= w_rd_temp;
                        end
                        2'd2: begin
                            r_g2 <= n_gap;
                            r_t2 <= w_rd_temp;
                        end
                        2'd3: begin
                            r_g3 <= n_gap;
                            r_t3 <= w_rd_temp;
                        end
                        default: begin
                        end
                    endcase
                    r_step <= r_step + 1'b1;
                    if (r_step == 2'd3) begin
                        r_state <= S_PICK;
                    end
                end

                S_PICK: begin
                    r_res_temp <= w_pick_temp;
                    r_res_oor  <= 1'b0;
                    r_state    <= S_EMIT;
                end

                S_EMIT: begin
                    // hold the result until the output register is free
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_temp  <= r_res_temp;
                        r_m_oor   <= r_res_oor;
                        r_state   <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid   = r_m_valid;
    assign m_axis_tdata    = r_m_temp;
    assign m_axis_tuser[0] = r_m_oor;

endmodule

// ===== rtl/thadc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module thadc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/thadc_div.sv =====
// Bit-serial restoring divider with a 32-bit saturated quotient.
`timescale 1ns / 1ps

module thadc_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  thadc_pkg::t_div_req                 i_req,
    output logic                                o_done,
    output logic [thadc_pkg::RES_W-1:0]         o_quotient
);

    localparam int DW  = thadc_pkg::DVD_W;
    localparam int SW  = thadc_pkg::DVS_W;
    localparam int RW  = thadc_pkg::RES_W;
    localparam int CTW = $clog2(DW);

    logic [DW-1:0]  r_dq;     // dividend shifts out at the top, quotient shifts in below
    logic [SW-1:0]  r_rem;
    logic [SW-1:0]  r_dvs;
    logic [CTW-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;

    logic [SW:0]    n_trial;
    logic           n_ge;
    logic [SW-1:0]  n_rem;

    always_comb begin
        n_trial = {r_rem, r_dq[DW-1]};
        n_ge    = (n_trial >= {1'b0, r_dvs});
        n_rem   = n_ge ? SW'(n_trial - {1'b0, r_dvs}) : n_trial[SW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_dq   <= i_req.dividend;
                r_dvs  <= i_req.divisor;
                r_rem  <= '0;
                r_cnt  <= CTW'(DW - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_dq  <= {r_dq[DW-2:0], n_ge};
                r_rem <= n_rem;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Clamp quotients that need more than 32 bits
    assign o_quotient = (|r_dq[DW-1:RW]) ? {RW{1'b1}} : r_dq[RW-1:0];
    assign o_done     = r_done;

endmodule

// ===== test/tb_thermistor_adc_to_temperature.sv =====
// Self-checking testbench for the thermistor ADC-to-temperature converter.
`timescale 1ns / 1ps

module tb_thermistor_adc_to_temperature;

    localparam int ROWS          = thadc_pkg::DEF_TABLE_DEPTH;
    localparam int SETTLE_CYCLES = 60;        // covers a full convert after the last word
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int TARGET_WORDS  = 1100;

    // Register slots that exist on the port but hold nothing
    localparam logic [thadc_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [thadc_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    // Marks a neighbor row that does not exist; larger than any real gap
    localparam logic [33:0] NO_ROW = 34'h2_0000_0000;

    // One input word; field order matches the tdata layout from the top bit down
    typedef struct packed {
        logic [thadc_pkg::ADC_W-1:0]         adc;
        logic signed [thadc_pkg::TEMP_W-1:0] temp;
        logic [thadc_pkg::RES_W-1:0]         res;
        logic [thadc_pkg::IDX_W-1:0]         row;
        logic                                op;
    } t_thermo_word;

    // One output word
    typedef struct packed {
        logic signed [thadc_pkg::TEMP_W-1:0] temp;
        logic                                oor;
    } t_reading;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_we = 1'b0;
    logic [thadc_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [thadc_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    // [5:0] entry_index, [37:6] entry_resistance, [53:38] entry_temperature,
    // [63:54] adc_sample
    logic [63:0]                      s_axis_tdata = '0;
    // [0] operation
    logic [0:0]                       s_axis_tuser = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    // [15:0] temperature
    logic [15:0]                      m_axis_tdata;
    // [0] out_of_range
    logic [0:0]                       m_axis_tuser;

    thermistor_adc_to_temperature DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    // Mirror of the block: lookup table and the two registers
    logic [thadc_pkg::RES_W-1:0]         res_col[ROWS];
    logic signed [thadc_pkg::TEMP_W-1:0] temp_col[ROWS];
    logic [thadc_pkg::CNT_REG_W-1:0]     count_reg = thadc_pkg::ENTRY_COUNT_RST;
    logic [thadc_pkg::PREC_W-1:0]        prec_reg = thadc_pkg::MATCH_PREC_RST;

    t_thermo_word pending_words[$];     // words not yet offered to the block
    t_reading     temps_due[$];         // readings predicted, oldest first
    t_thermo_word held_word = '0;
    t_reading     reading_due;
    logic         word_held = 1'b0;
    bit           send_calm = 1'b0;
    bit           take_calm = 1'b0;
    int           send_wait = 0;
    int           take_wait = 0;
    int           words_queued = 0;
    int           loads_done = 0;
    int           conversions_checked = 0;
    int           out_of_range_seen = 0;
    int           settings_used = 0;
    int           fail_count = 0;
    int           cycle_count = 0;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Entry count as the search uses it: zero acts as one, clamp at depth
    function automatic int active_rows();
        if (count_reg == 0) return 1;
        if (count_reg > ROWS) return ROWS;
        return int'(count_reg);
    endfunction

    // Q16.16 resistance of a sample with a positive divisor, saturated to 32 bits
    function automatic logic [thadc_pkg::RES_W-1:0] thermistor_res(
        input logic [thadc_pkg::ADC_W-1:0] adc);
        longint      divisor;
        logic [63:0] quot;
        divisor = longint'(thadc_pkg::DIV_BASE)
                  - longint'(thadc_pkg::DIV_SLOPE) * longint'(adc);
        quot = (64'(adc) * 64'(thadc_pkg::ADC_GAIN) * (64'd1 << thadc_pkg::FRAC_W))
               / 64'(divisor);
        return (quot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
    endfunction

    function automatic logic [33:0] res_gap(input logic [thadc_pkg::RES_W-1:0] a,
                                            input logic [thadc_pkg::RES_W-1:0] b);
        return (a >= b) ? 34'(a - b) : 34'(b - a);
    endfunction

    // Reading the block must produce for one sample, given the current mirror
    function automatic t_reading convert_sample(input logic [thadc_pkg::ADC_W-1:0] adc);
        t_reading                    rd;
        logic [thadc_pkg::RES_W-1:0] r;
        int                          rows, lo, hi, mid, pick;
        logic [33:0]                 d_prev, d_next, d_here;
        rd.temp = '0;
        rd.oor  = 1'b1;
        // no positive divisor: out of range outright
        if (adc >= thadc_pkg::ADC_LIMIT) return rd;
        rows = active_rows();
        r = thermistor_res(adc);
        // span check against the first and the last row in use
        if (r < res_col[rows-1] || r > res_col[0]) return rd;
        rd.oor = 1'b0;
        lo  = 0;
        hi  = rows - 1;
        mid = (lo + hi) / 2;
        while (lo + 1 < hi) begin
            // early hit; an exact match counts even at zero precision
            if (res_gap(r, res_col[mid]) < 34'(prec_reg) || r == res_col[mid]) begin
                rd.temp = temp_col[mid];
                return rd;
            end
            if (r < res_col[mid]) lo = mid;
            else hi = mid;
            mid = (lo + hi) / 2;
        end
        // nearest of mid-1, mid, mid+1; a missing row never wins
        d_prev = (mid >= 1) ? res_gap(r, res_col[mid-1]) : NO_ROW;
        d_next = (mid + 1 < rows) ? res_gap(r, res_col[mid+1]) : NO_ROW;
        d_here = res_gap(r, res_col[mid]);
        if (d_prev <= d_next && d_prev <= d_here) pick = mid - 1;
        else if (d_next <= d_prev && d_next <= d_here) pick = mid + 1;
        else pick = mid;
        rd.temp = temp_col[pick];
        return rd;
    endfunction

    function automatic int draw_wait(input bit calm);
        return calm ? 0 : int'($urandom_range(0, 12));
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer queued words, update the mirror on each accepted word
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            word_held = 1'b0;
            send_wait = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (held_word.op == thadc_pkg::OP_CONVERT) begin
                    temps_due.push_back(convert_sample(held_word.adc));
                end else begin
                    res_col[held_word.row]  = held_word.res;
                    temp_col[held_word.row] = held_word.temp;
                    loads_done++;
                end
                word_held = 1'b0;
            end
            // hold off for the drawn gap, then take the next word
            if (!word_held) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (pending_words.size() > 0) begin
                    held_word = pending_words.pop_front();
                    word_held = 1'b1;
                    if ($urandom_range(0, 30) == 0) send_calm = !send_calm;
                    send_wait = draw_wait(send_calm);
                end
            end
            s_axis_tvalid <= word_held;
            s_axis_tdata  <= {held_word.adc, held_word.temp, held_word.res, held_word.row};
            s_axis_tuser  <= held_word.op;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each reading with the oldest prediction, then stall
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            take_wait = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (temps_due.size() == 0) begin
                    $display("%0t: unexpected reading, expected none, got temperature %0d oor %0b",
                             $time, $signed(m_axis_tdata), m_axis_tuser[0]);
                    fail_count++;
                end else begin
                    reading_due = temps_due.pop_front();
                    if (m_axis_tdata !== reading_due.temp) begin
                        $display("%0t: temperature mismatch, expected %0d, got %0d",
                                 $time, reading_due.temp, $signed(m_axis_tdata));
                        fail_count++;
                    end
                    if (m_axis_tuser[0] !== reading_due.oor) begin
                        $display("%0t: out_of_range mismatch, expected %0b, got %0b",
                                 $time, reading_due.oor, m_axis_tuser[0]);
                        fail_count++;
                    end
                    conversions_checked++;
                    if (reading_due.oor) out_of_range_seen++;
                end
                if ($urandom_range(0, 30) == 0) take_calm = !take_calm;
                take_wait = draw_wait(take_calm);
            end else if (take_wait > 0) begin
                take_wait--;
            end
            m_axis_tready <= (take_wait == 0);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: no completion after %0d cycles, %0d readings outstanding",
                     $time, cycle_count, temps_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Unused fields carry random bits so every tdata bit toggles
    function automatic void queue_load(input logic [thadc_pkg::IDX_W-1:0] row,
                                       input logic [thadc_pkg::RES_W-1:0] res,
                                       input logic signed [thadc_pkg::TEMP_W-1:0] temp);
        t_thermo_word w;
        w.op   = thadc_pkg::OP_LOAD;
        w.row  = row;
        w.res  = res;
        w.temp = temp;
        w.adc  = 10'($urandom);
        pending_words.push_back(w);
        words_queued++;
    endfunction

    function automatic void queue_convert(input logic [thadc_pkg::ADC_W-1:0] adc);
        t_thermo_word w;
        w.op   = thadc_pkg::OP_CONVERT;
        w.row  = 6'($urandom);
        w.res  = $urandom;
        w.temp = 16'($urandom);
        w.adc  = adc;
        pending_words.push_back(w);
        words_queued++;
    endfunction

    // Registers change only while the block is idle
    task automatic write_reg(input logic [thadc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [thadc_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            thadc_pkg::CFG_ENTRY_COUNT: count_reg = val[thadc_pkg::CNT_REG_W-1:0];
            thadc_pkg::CFG_MATCH_PREC:  prec_reg  = val[thadc_pkg::PREC_W-1:0];
            default: ;
        endcase
    endtask

    // Wait until the sender is empty and every reading is back, then let a convert finish
    task automatic wait_drained();
        while (pending_words.size() != 0 || word_held || temps_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register setting: load rows 0..rows-1 of the effective count, then convert against them
    task automatic random_phase(input int p);
        logic [thadc_pkg::RES_W-1:0]     tab_res[ROWS];
        logic [thadc_pkg::ADC_W-1:0]     tab_adc[ROWS];
        logic [thadc_pkg::CNT_REG_W-1:0] count_val;
        logic [thadc_pkg::PREC_W-1:0]    prec_val;
        longint                          v;
        int                              rows, hi_adc, lo_adc, n_conv, pick, i;
        bit                              noisy;
        // first settings hit the count extremes, including the clamped ones
        case (p)
            0:       count_val = 7'd1;
            1:       count_val = 7'd0;
            2:       count_val = 7'd64;
            3:       count_val = 7'd127;
            4:       count_val = 7'd2;
            5:       count_val = 7'd65;
            default: count_val = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                                             : 7'($urandom_range(3, 64));
        endcase
        case (p % 5)
            0:       prec_val = 16'd0;
            1:       prec_val = 16'hFFFF;
            2:       prec_val = thadc_pkg::MATCH_PREC_RST;
            3:       prec_val = 16'($urandom_range(0, 255));
            default: prec_val = 16'($urandom);
        endcase
        // upper data bits above the count field are random and must be dropped
        write_reg(thadc_pkg::CFG_ENTRY_COUNT, {9'($urandom), count_val});
        write_reg(thadc_pkg::CFG_MATCH_PREC, prec_val);
        if (p < 2 || $urandom_range(0, 3) == 0)
            write_reg(p[0] ? CFG_SPARE_HI : CFG_SPARE_LO, 16'($urandom));
        rows  = active_rows();
        noisy = (p > 5) && ($urandom_range(0, 5) == 0);
        hi_adc = $urandom_range(60, thadc_pkg::ADC_LIMIT - 1);
        lo_adc = $urandom_range(0, hi_adc - 50);
        // well-formed: resistance of evenly spread samples, jittered, kept descending
        for (i = 0; i < rows; i++) begin
            tab_adc[i] = 10'((rows > 1) ? hi_adc - ((hi_adc - lo_adc) * i) / (rows - 1) : hi_adc);
            if (noisy) begin
                tab_res[i] = $urandom;
            end else begin
                v = longint'(thermistor_res(tab_adc[i]));
                if ($urandom_range(0, 1) == 1) v = v + longint'($urandom_range(0, 4000)) - 2000;
                if (v < 0) v = 0;
                if (v > longint'(32'hFFFF_FFFF)) v = longint'(32'hFFFF_FFFF);
                if (i > 0 && v > longint'(tab_res[i-1])) v = longint'(tab_res[i-1]);
                tab_res[i] = v[31:0];
            end
            queue_load(6'(i), tab_res[i], 16'($urandom));
        end
        n_conv = $urandom_range(30, 80);
        repeat (n_conv) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                // stray rewrite of any row, may break the order
                queue_load(6'($urandom_range(0, ROWS - 1)), $urandom, 16'($urandom));
            else if (pick <= 3 || noisy)
                queue_convert(10'($urandom_range(0, 1023)));
            else if (pick <= 8)
                // sample that lands on a row before jitter
                queue_convert(tab_adc[$urandom_range(0, rows - 1)]);
            else
                queue_convert(10'($urandom_range(lo_adc > 5 ? lo_adc - 5 : 0, hi_adc + 5)));
        end
        settings_used++;
        wait_drained();
    endtask

    initial begin
        logic [thadc_pkg::RES_W-1:0] mid_r;
        int                          p;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Five rows spanning zero to full scale, zero precision
        write_reg(thadc_pkg::CFG_ENTRY_COUNT, 16'd5);
        write_reg(thadc_pkg::CFG_MATCH_PREC, 16'd0);
        queue_load(6'd0, 32'hFFFF_FFFF, 16'sh7FFF);
        queue_load(6'd1, thermistor_res(10'd600), 16'sh8000);
        queue_load(6'd2, thermistor_res(10'd300), 16'sh0000);
        queue_load(6'd3, thermistor_res(10'd100), 16'sh0001);
        queue_load(6'd4, 32'd0, 16'shFFFF);
        queue_convert(10'd0);      // zero resistance, bottom row
        queue_convert(10'd937);    // saturated resistance equals row 0
        queue_convert(10'd938);    // first sample with a negative divisor
        queue_convert(10'd1023);   // divisor negative
        queue_convert(10'd300);    // exact hit on the first probe at zero precision
        queue_convert(10'd600);
        queue_convert(10'd100);
        queue_convert(10'd1);
        queue_convert(10'd450);
        queue_convert(10'd936);
        settings_used++;
        wait_drained();

        // Three rows, one search step that settles on the center row: walk the tie-break order
        write_reg(thadc_pkg::CFG_ENTRY_COUNT, 16'd3);
        mid_r = thermistor_res(10'd500);
        queue_load(6'd0, mid_r + 32'd1000, 16'sd100);
        queue_load(6'd1, mid_r + 32'd1000, 16'sd200);
        queue_load(6'd2, mid_r - 32'd1000, 16'sd300);
        queue_convert(10'd500);    // three-way tie goes to the row before the center
        queue_load(6'd0, mid_r + 32'd2000, 16'sd100);
        queue_convert(10'd500);    // tie between center and the row after it goes to that row
        queue_load(6'd1, mid_r + 32'd1, 16'sd200);
        queue_convert(10'd500);    // center row closest
        settings_used++;
        wait_drained();

        p = 0;
        while (words_queued < TARGET_WORDS) begin
            random_phase(p);
            p++;
        end
        wait_drained();

        $display("Checked %0d conversions (%0d out of range) against %0d table loads",
                 conversions_checked, out_of_range_seen, loads_done);
        $display("over %0d register settings, entry counts 0 to 127, precision 0 to 65535.",
                 settings_used);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/thadc_pkg.sv
rtl/thadc_ram.sv
rtl/thadc_div.sv
rtl/thermistor_adc_to_temperature.sv
test/tb_thermistor_adc_to_temperature.sv
